// File: rtl/dcfir_pkg.sv
package dcfir_pkg;

  localparam int unsigned MAX_TAPS   = 64;
  localparam int unsigned SAMP_W     = 16;
  localparam int unsigned COEF_IDX_W = 6;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned DEC_W      = 9;
  localparam int unsigned TAPS_W     = 7;
  localparam int unsigned PHASE_W    = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  // one complex product term: difference or sum of two 16x16 products
  localparam int unsigned PROD_W     = 2 * SAMP_W + 1;

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_LOAD   = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECIMATION = 1'b0,
    CFG_TAP_COUNT  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                    shift;
    logic                    load;
    logic [COEF_IDX_W-1:0]   index;
    logic signed [SAMP_W-1:0] coef_i;
    logic signed [SAMP_W-1:0] coef_q;
  } cell_ctrl_t;

endpackage

// File: rtl/dcfir_cell.sv
module dcfir_cell #(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned AccW    = 40
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  dcfir_pkg::cell_ctrl_t                   ctrl_i,
  input  logic                                    tap_en_i,
  input  logic signed [dcfir_pkg::SAMP_W-1:0]     samp_i_i,
  input  logic signed [dcfir_pkg::SAMP_W-1:0]     samp_q_i,
  output logic signed [dcfir_pkg::SAMP_W-1:0]     samp_i_o,
  output logic signed [dcfir_pkg::SAMP_W-1:0]     samp_q_o,
  input  logic signed [AccW-1:0]                  acc_i_i,
  input  logic signed [AccW-1:0]                  acc_q_i,
  output logic signed [AccW-1:0]                  acc_i_o,
  output logic signed [AccW-1:0]                  acc_q_o
);

  localparam int unsigned SW = dcfir_pkg::SAMP_W;
  localparam int unsigned PW = dcfir_pkg::PROD_W;

  logic signed [SW-1:0]   samp_i_q, samp_q_q, coef_i_q, coef_q_q;
  logic signed [2*SW-1:0] m_ii, m_qq, m_iq, m_qi;
  logic signed [PW-1:0]   prod_i_d, prod_q_d, prod_i_q, prod_q_q;
  logic signed [AccW-1:0] acc_i_d, acc_q_d, acc_i_q, acc_q_q;
  logic                   coef_hit;

  assign coef_hit = ctrl_i.load && (int'(ctrl_i.index) == CellIdx);

  // delay line tap and coefficient slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_i_q <= '0;
      samp_q_q <= '0;
      coef_i_q <= '0;
      coef_q_q <= '0;
    end else begin
      if (ctrl_i.shift) begin
        samp_i_q <= samp_i_i;
        samp_q_q <= samp_q_i;
      end
      if (coef_hit) begin
        coef_i_q <= ctrl_i.coef_i;
        coef_q_q <= ctrl_i.coef_q;
      end
    end
  end

  assign m_ii = (2*SW)'(samp_i_q) * (2*SW)'(coef_i_q);
  assign m_qq = (2*SW)'(samp_q_q) * (2*SW)'(coef_q_q);
  assign m_iq = (2*SW)'(samp_i_q) * (2*SW)'(coef_q_q);
  assign m_qi = (2*SW)'(samp_q_q) * (2*SW)'(coef_i_q);

  assign prod_i_d = PW'(m_ii) - PW'(m_qq);
  assign prod_q_d = PW'(m_iq) + PW'(m_qi);

  // partial sum arrives from the previous cell, leaves in the next cycle
  assign acc_i_d = acc_i_i + (tap_en_i ? AccW'(prod_i_q) : '0);
  assign acc_q_d = acc_q_i + (tap_en_i ? AccW'(prod_q_q) : '0);

  always_ff @(posedge clk_i) begin
    prod_i_q <= prod_i_d;
    prod_q_q <= prod_q_d;
    acc_i_q  <= acc_i_d;
    acc_q_q  <= acc_q_d;
  end

  assign samp_i_o = samp_i_q;
  assign samp_q_o = samp_q_q;
  assign acc_i_o  = acc_i_q;
  assign acc_q_o  = acc_q_q;

endmodule

// File: rtl/decimating_complex_fir_filter_unit.sv
// Channel  Dir  Handshake                 Beat
// in       in   in_valid_i / in_stall_o   opcode, sample_i/q, coef_index, coef_i/q
// out      out  out_valid_o / out_stall_i out_i, out_q
// cfg      in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Coefficient loads and samples that emit nothing are taken back to back while idle.
// An emitting sample passes one product stage, then the partial sum walks the
// MaxTaps-cell chain, then the output register.
// in_stall_o is high while the chain sums; the result may wait in the output
// register while the next beats are taken.
// Reset clears delay line, coefficients and phase, and sets the configuration registers to their defaults.
module decimating_complex_fir_filter_unit #(
  parameter int unsigned MaxTaps = dcfir_pkg::MAX_TAPS
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_stall_o,
  input  logic                                          opcode_i,
  input  logic signed [dcfir_pkg::SAMP_W-1:0]           sample_i_i,
  input  logic signed [dcfir_pkg::SAMP_W-1:0]           sample_q_i,
  input  logic [dcfir_pkg::COEF_IDX_W-1:0]              coef_index_i,
  input  logic signed [dcfir_pkg::SAMP_W-1:0]           coef_i_i,
  input  logic signed [dcfir_pkg::SAMP_W-1:0]           coef_q_i,
  output logic                                          out_valid_o,
  input  logic                                          out_stall_i,
  output logic signed [dcfir_pkg::OUT_W-1:0]            out_i_o,
  output logic signed [dcfir_pkg::OUT_W-1:0]            out_q_o,
  input  logic                                          cfg_we_i,
  input  logic [dcfir_pkg::CFG_IDX_W-1:0]               cfg_idx_i,
  input  logic [dcfir_pkg::CFG_DATA_W-1:0]              cfg_data_i
);

  localparam int unsigned SW    = dcfir_pkg::SAMP_W;
  localparam int unsigned OW    = dcfir_pkg::OUT_W;
  localparam int unsigned AccW  = dcfir_pkg::PROD_W + $clog2(MaxTaps + 1) + 1;
  localparam int unsigned CntW  = $clog2(MaxTaps + 2);
  localparam logic [CntW-1:0] CntLast = CntW'(MaxTaps + 1);
  localparam logic signed [OW-1:0] SatMax = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] SatMin = {1'b1, {(OW-1){1'b0}}};

  dcfir_pkg::state_e                      state_q, state_d;
  logic [CntW-1:0]                        cnt_q, cnt_d;
  logic [dcfir_pkg::PHASE_W-1:0]          phase_q, phase_d, dec_m1;
  logic [dcfir_pkg::DEC_W-1:0]            decim_q, dec_eff;
  logic [dcfir_pkg::TAPS_W-1:0]           taps_q;
  logic                                   out_valid_q;
  logic signed [OW-1:0]                   out_i_q, out_q_q, sat_i, sat_q;
  logic signed [AccW-1:0]                 shr_i, shr_q;
  logic                                   in_acc, is_filter, is_load, finish;
  dcfir_pkg::cell_ctrl_t                  ctrl;

  logic signed [SW-1:0]   samp_i_ch [MaxTaps+1];
  logic signed [SW-1:0]   samp_q_ch [MaxTaps+1];
  logic signed [AccW-1:0] acc_i_ch  [MaxTaps+1];
  logic signed [AccW-1:0] acc_q_ch  [MaxTaps+1];

  assign in_stall_o = (state_q != dcfir_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_filter  = in_acc && (opcode_i == dcfir_pkg::OP_FILTER);
  assign is_load    = in_acc && (opcode_i == dcfir_pkg::OP_LOAD);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q <= dcfir_pkg::DEC_W'(1);
      taps_q  <= dcfir_pkg::TAPS_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dcfir_pkg::CFG_DECIMATION: decim_q <= cfg_data_i;
        dcfir_pkg::CFG_TAP_COUNT:  taps_q  <= cfg_data_i[dcfir_pkg::TAPS_W-1:0];
        default: ;
      endcase
    end
  end

  // decimation phase
  always_comb begin
    if (decim_q == '0) begin
      dec_eff = dcfir_pkg::DEC_W'(1);
    end else if (decim_q > dcfir_pkg::DEC_W'(256)) begin
      dec_eff = dcfir_pkg::DEC_W'(256);
    end else begin
      dec_eff = decim_q;
    end
    dec_m1  = dcfir_pkg::PHASE_W'(dec_eff - dcfir_pkg::DEC_W'(1));
    phase_d = (phase_q >= dec_m1) ? '0 : phase_q + 1'b1;
  end

  // sequencer: an emitting sample holds the input while the chain sums
  assign finish = (state_q == dcfir_pkg::ST_BUSY) && (cnt_q == CntLast)
               && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      dcfir_pkg::ST_IDLE: begin
        if (is_filter && (phase_q == '0)) begin
          state_d = dcfir_pkg::ST_BUSY;
          cnt_d   = '0;
        end
      end
      dcfir_pkg::ST_BUSY: begin
        if (cnt_q != CntLast) begin
          cnt_d = cnt_q + 1'b1;
        end else if (finish) begin
          state_d = dcfir_pkg::ST_IDLE;
        end
      end
      default: state_d = dcfir_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcfir_pkg::ST_IDLE;
      cnt_q       <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (is_filter) begin
        phase_q <= phase_d;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // floor shift by 15, saturate to 32 bits
  assign shr_i = acc_i_ch[MaxTaps] >>> 15;
  assign shr_q = acc_q_ch[MaxTaps] >>> 15;
  assign sat_i = (shr_i > AccW'(SatMax)) ? SatMax :
                 (shr_i < AccW'(SatMin)) ? SatMin : OW'(shr_i);
  assign sat_q = (shr_q > AccW'(SatMax)) ? SatMax :
                 (shr_q < AccW'(SatMin)) ? SatMin : OW'(shr_q);

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_i_q <= sat_i;
      out_q_q <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_i_o     = out_i_q;
  assign out_q_o     = out_q_q;

  // cell row
  assign ctrl.shift  = is_filter;
  assign ctrl.load   = is_load;
  assign ctrl.index  = coef_index_i;
  assign ctrl.coef_i = coef_i_i;
  assign ctrl.coef_q = coef_q_i;

  assign samp_i_ch[0] = sample_i_i;
  assign samp_q_ch[0] = sample_q_i;
  assign acc_i_ch[0]  = '0;
  assign acc_q_ch[0]  = '0;

  for (genvar k = 0; k < MaxTaps; k++) begin : g_cell
    logic tap_en;
    assign tap_en = (k == 0) || (int'(taps_q) > k);

    dcfir_cell #(
      .CellIdx (k),
      .AccW    (AccW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .tap_en_i (tap_en),
      .samp_i_i (samp_i_ch[k]),
      .samp_q_i (samp_q_ch[k]),
      .samp_i_o (samp_i_ch[k+1]),
      .samp_q_o (samp_q_ch[k+1]),
      .acc_i_i  (acc_i_ch[k]),
      .acc_q_i  (acc_q_ch[k]),
      .acc_i_o  (acc_i_ch[k+1]),
      .acc_q_o  (acc_q_ch[k+1])
    );
  end

  a_emit_starts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_filter && (phase_q == '0)) |=> (state_q == dcfir_pkg::ST_BUSY) && (cnt_q == '0))
    else $error("emitting sample did not start the chain sum");

  a_silent_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_load || (is_filter && (phase_q != '0))) |=> (state_q == dcfir_pkg::ST_IDLE))
    else $error("item without result left the idle state");

  a_result_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == dcfir_pkg::ST_BUSY && cnt_q == CntLast))
    else $error("result appeared without a finished sum");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dcfir_pkg::ST_BUSY) |-> (cnt_q <= CntLast))
    else $error("sum counter overran");

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = dcfir_pkg::MAX_TAPS + 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 600000;

  typedef struct packed {
    logic signed [dcfir_pkg::OUT_W-1:0] re;
    logic signed [dcfir_pkg::OUT_W-1:0] im;
  } fir_out_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic                                in_valid = 1'b0;
  logic                                in_stall;
  dcfir_pkg::opcode_e                  in_op = dcfir_pkg::OP_FILTER;
  logic signed [dcfir_pkg::SAMP_W-1:0] in_si = '0;
  logic signed [dcfir_pkg::SAMP_W-1:0] in_sq = '0;
  logic [dcfir_pkg::COEF_IDX_W-1:0]    in_idx = '0;
  logic signed [dcfir_pkg::SAMP_W-1:0] in_ci = '0;
  logic signed [dcfir_pkg::SAMP_W-1:0] in_cq = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [dcfir_pkg::OUT_W-1:0]  out_re;
  logic signed [dcfir_pkg::OUT_W-1:0]  out_im;
  logic                                cfg_we = 1'b0;
  dcfir_pkg::cfg_reg_e                 cfg_idx = dcfir_pkg::CFG_DECIMATION;
  logic [dcfir_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

  // filter model state
  logic signed [dcfir_pkg::SAMP_W-1:0] m_coef_re[dcfir_pkg::MAX_TAPS];
  logic signed [dcfir_pkg::SAMP_W-1:0] m_coef_im[dcfir_pkg::MAX_TAPS];
  logic signed [dcfir_pkg::SAMP_W-1:0] m_line_re[dcfir_pkg::MAX_TAPS];
  logic signed [dcfir_pkg::SAMP_W-1:0] m_line_im[dcfir_pkg::MAX_TAPS];
  logic [dcfir_pkg::PHASE_W-1:0]       m_phase;
  logic [dcfir_pkg::DEC_W-1:0]         m_decimation;
  logic [dcfir_pkg::TAPS_W-1:0]        m_tap_count;

  fir_out_t pending_outputs[$];
  int       mismatch_count = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       hold_left = 0;
  bit       hold_req = 1'b0;

  decimating_complex_fir_filter_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (in_op),
    .sample_i_i   (in_si),
    .sample_q_i   (in_sq),
    .coef_index_i (in_idx),
    .coef_i_i     (in_ci),
    .coef_q_i     (in_cq),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_i_o      (out_re),
    .out_q_o      (out_im),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(string what, logic signed [dcfir_pkg::OUT_W-1:0] got,
                                 logic signed [dcfir_pkg::OUT_W-1:0] want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic signed [dcfir_pkg::OUT_W-1:0] sat32(longint x);
    if (x > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (x < -longint'(64'sh80000000)) return 32'sh80000000;
    return x[dcfir_pkg::OUT_W-1:0];
  endfunction

  function automatic void model_reset();
    for (int k = 0; k < dcfir_pkg::MAX_TAPS; k++) begin
      m_coef_re[k] = '0;
      m_coef_im[k] = '0;
      m_line_re[k] = '0;
      m_line_im[k] = '0;
    end
    m_phase      = '0;
    m_decimation = dcfir_pkg::DEC_W'(1);
    m_tap_count  = dcfir_pkg::TAPS_W'(64);
  endfunction

  function automatic void model_config(dcfir_pkg::cfg_reg_e idx,
                                       logic [dcfir_pkg::CFG_DATA_W-1:0] data);
    if (idx == dcfir_pkg::CFG_DECIMATION) m_decimation = data[dcfir_pkg::DEC_W-1:0];
    else m_tap_count = data[dcfir_pkg::TAPS_W-1:0];
  endfunction

  // advance the filter model by one beat, queue the output if one is due
  function automatic void predict_filter_output(dcfir_pkg::opcode_e op,
      logic signed [dcfir_pkg::SAMP_W-1:0] si, logic signed [dcfir_pkg::SAMP_W-1:0] sq,
      logic [dcfir_pkg::COEF_IDX_W-1:0] idx, logic signed [dcfir_pkg::SAMP_W-1:0] ci,
      logic signed [dcfir_pkg::SAMP_W-1:0] cq);
    int       dec;
    int       taps;
    bit       emit;
    longint   acc_re;
    longint   acc_im;
    longint   sr, sx, cr, cx;
    fir_out_t res;
    if (op == dcfir_pkg::OP_LOAD) begin
      m_coef_re[idx] = ci;
      m_coef_im[idx] = cq;
      return;
    end
    for (int k = dcfir_pkg::MAX_TAPS - 1; k > 0; k--) begin
      m_line_re[k] = m_line_re[k-1];
      m_line_im[k] = m_line_im[k-1];
    end
    m_line_re[0] = si;
    m_line_im[0] = sq;
    dec  = (m_decimation == 0) ? 1 : (m_decimation > 256) ? 256 : int'(m_decimation);
    taps = (m_tap_count == 0) ? 1 :
           (m_tap_count > dcfir_pkg::MAX_TAPS) ? dcfir_pkg::MAX_TAPS : int'(m_tap_count);
    emit = (m_phase == 0);
    if (int'(m_phase) >= dec - 1) m_phase = '0;
    else m_phase = m_phase + 1'b1;
    if (!emit) return;
    acc_re = 0;
    acc_im = 0;
    for (int k = 0; k < taps; k++) begin
      sr = m_line_re[k];
      sx = m_line_im[k];
      cr = m_coef_re[k];
      cx = m_coef_im[k];
      acc_re += sr * cr - sx * cx;
      acc_im += sr * cx + sx * cr;
    end
    res.re = sat32(acc_re >>> 15);
    res.im = sat32(acc_im >>> 15);
    pending_outputs.push_back(res);
  endfunction

  // Called right after a rising edge; returns right after the accepting edge
  // with in_valid still high, so the caller must drive in_valid in that step.
  task automatic send_beat(dcfir_pkg::opcode_e op, logic signed [dcfir_pkg::SAMP_W-1:0] si,
                           logic signed [dcfir_pkg::SAMP_W-1:0] sq,
                           logic [dcfir_pkg::COEF_IDX_W-1:0] idx,
                           logic signed [dcfir_pkg::SAMP_W-1:0] ci,
                           logic signed [dcfir_pkg::SAMP_W-1:0] cq);
    bit fire;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_si    <= si;
    in_sq    <= sq;
    in_idx   <= idx;
    in_ci    <= ci;
    in_cq    <= cq;
    do begin
      @(negedge clk);
      fire = !in_stall;
      @(posedge clk);
    end while (!fire);
    predict_filter_output(op, si, sq, idx, ci, cq);
  endtask

  task automatic send_sample(logic signed [dcfir_pkg::SAMP_W-1:0] si,
                             logic signed [dcfir_pkg::SAMP_W-1:0] sq);
    send_beat(dcfir_pkg::OP_FILTER, si, sq, 6'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_coef(logic [dcfir_pkg::COEF_IDX_W-1:0] idx,
                           logic signed [dcfir_pkg::SAMP_W-1:0] ci,
                           logic signed [dcfir_pkg::SAMP_W-1:0] cq);
    send_beat(dcfir_pkg::OP_LOAD, 16'($urandom), 16'($urandom), idx, ci, cq);
  endtask

  // stop sending and wait until every output is out and the chain is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(dcfir_pkg::cfg_reg_e idx, logic [dcfir_pkg::CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    model_config(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [dcfir_pkg::SAMP_W-1:0] rand_word();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stalls, or one long hold-off when requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // output beat is taken at the next rising edge; all signals are settled here
  always @(negedge clk) begin
    fir_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected output out_i", out_re, '0);
      end else begin
        want = pending_outputs.pop_front();
        if (out_re !== want.re) report_mismatch("out_i", out_re, want.re);
        if (out_im !== want.im) report_mismatch("out_q", out_im, want.im);
      end
    end
  end

  task automatic test_reset_state();
    // zero coefficients after reset; the very first sample emits
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'shffff, 16'sh0001);
  endtask

  task automatic test_coef_extremes();
    send_coef(6'd0, 16'sh7fff, 16'sh8000);
    send_coef(6'd63, 16'sh8000, 16'sh7fff);
    send_coef(6'd1, 16'shffff, 16'sh0001);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'shffff, 16'shffff);
    drain();
    cfg_write(dcfir_pkg::CFG_TAP_COUNT, 9'd127);
    send_sample(16'sh8000, 16'sh8000);
    drain();
    cfg_write(dcfir_pkg::CFG_TAP_COUNT, 9'd0);
    send_sample(16'sh7fff, 16'sh7fff);
    drain();
    cfg_write(dcfir_pkg::CFG_TAP_COUNT, 9'd1);
    send_sample(16'sh8000, 16'sh0001);
  endtask

  task automatic test_decimation_extremes();
    drain();
    cfg_write(dcfir_pkg::CFG_TAP_COUNT, 9'd64);
    cfg_write(dcfir_pkg::CFG_DECIMATION, 9'd0);
    send_sample(16'sh1234, 16'shedcb);
    send_sample(16'sh8000, 16'sh7fff);
    drain();
    cfg_write(dcfir_pkg::CFG_DECIMATION, 9'd256);
    repeat (3) send_sample(rand_word(), rand_word());
    drain();
    cfg_write(dcfir_pkg::CFG_DECIMATION, 9'd511);
    repeat (2) send_sample(rand_word(), rand_word());
  endtask

  task automatic test_lowered_decimation();
    drain();
    cfg_write(dcfir_pkg::CFG_DECIMATION, 9'd8);
    repeat (5) send_sample(rand_word(), rand_word());
    drain();
    // phase sits past the new limit: next sample wraps without output
    cfg_write(dcfir_pkg::CFG_DECIMATION, 9'd2);
    repeat (3) send_sample(rand_word(), rand_word());
  endtask

  task automatic test_random_phase(int dec, int taps, int idle, int stall, int n,
                                   bit hold_off);
    int used;
    drain();
    cfg_write(dcfir_pkg::CFG_DECIMATION, 9'(dec));
    cfg_write(dcfir_pkg::CFG_TAP_COUNT, 9'(taps));
    idle_pct  = idle;
    stall_pct = stall;
    used = (taps[6:0] == 0) ? 1 :
           (taps[6:0] > dcfir_pkg::MAX_TAPS) ? dcfir_pkg::MAX_TAPS : taps[6:0];
    // a full coefficient set first, then a sample stream with stray loads
    for (int k = 0; k < used; k++) send_coef(6'(k), rand_word(), rand_word());
    for (int k = 0; k < n; k++) begin
      if (hold_off && k == 10) hold_req = 1'b1;
      if ($urandom_range(99) < 15) send_coef(6'($urandom), rand_word(), rand_word());
      else send_sample(rand_word(), rand_word());
    end
  endtask

  task automatic test_backpressure();
    // long receiver hold-off with a steady sender: input must stall
    test_random_phase(1, 64, 0, 0, 60, 1'b1);
  endtask

  initial begin
    model_reset();
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_coef_extremes();
    test_decimation_extremes();
    test_lowered_decimation();
    test_backpressure();
    test_random_phase(3, 5, 52, 0, 60, 1'b0);
    test_random_phase(1, 1, 0, 52, 60, 1'b0);
    test_random_phase(7, 17, 16, 16, 60, 1'b0);
    test_random_phase(0, 0, 16, 16, 40, 1'b0);
    test_random_phase(2, 9'h180 | 33, 52, 52, 60, 1'b0);
    test_random_phase(511, 127, 0, 0, 60, 1'b0);
    test_random_phase(1, 64, 16, 16, 40, 1'b0);

    drain();
    while (pending_outputs.size() != 0) begin
      report_mismatch("missing output", '0, pending_outputs[0].re);
      void'(pending_outputs.pop_front());
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
